// ===== sv/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, codes and field layout for the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

    // default sizing
    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // field widths
    localparam int CMD_W  = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;

    // stream payload layout
    localparam int IN_FIELDS_W  = CMD_W + WORD_W + POS_W;
    localparam int OUT_FIELDS_W = STAT_W + WORD_W + 1 + POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // output field offsets
    localparam int O_DATA_LSB  = STAT_W;
    localparam int O_FOUND_BIT = STAT_W + WORD_W;
    localparam int O_LEN_LSB   = STAT_W + WORD_W + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_END = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // operation broadcast to the cell row
    typedef struct packed {
        logic ins;  // write at idx, cells above take left neighbor
        logic rem;  // cells at idx and above take right neighbor
    } cell_op_t;

endpackage

// ===== sv/ale_cell.sv =====
// ----------------------------------------------------------------------------
// ale_cell
// One list slot: holds an entry, shifts with its neighbors, compares and reads.
// ----------------------------------------------------------------------------
module ale_cell
    import ale_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
)
(
    input  logic                   clk,
    input  cell_op_t               op,
    input  logic [IDX_W-1:0]       idx,
    input  logic [CNT_W-1:0]       count,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] left,
    input  logic [VALUE_WIDTH-1:0] right,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   hit,
    output logic [VALUE_WIDTH-1:0] rdata
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins)
        begin
            if (MY_IDX == idx)
                entry_next = value;
            else if (MY_IDX > idx)
                entry_next = left;
        end
        else if (op.rem)
        begin
            if (MY_IDX >= idx)
                entry_next = right;
        end
    end

    // entry storage needs no reset: only held slots are ever looked at
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hit   = (MY_CNT < count) && (entry_reg == value);
    assign rdata = (MY_IDX == idx) ? entry_reg : '0;

endmodule

// ===== sv/ale_ctrl.sv =====
// ----------------------------------------------------------------------------
// ale_ctrl
// Command decode, length counter and result register for the list engine.
// ----------------------------------------------------------------------------
module ale_ctrl
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [POS_W-1:0]  position,
    input  logic [WORD_W-1:0] sel_word,
    input  logic              any_hit,
    output cell_op_t          op,
    output logic [IDX_W-1:0]  idx,
    output logic [CNT_W-1:0]  count,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [STAT_W-1:0] status,
    output logic [WORD_W-1:0] data_out,
    output logic              found,
    output logic [POS_W-1:0]  length
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [WORD_W-1:0] data_reg;
    logic              found_reg;
    logic [POS_W-1:0]  length_reg;

    logic              fire;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    cell_op_t          op_c;
    logic              rd_c;
    logic              found_c;
    logic [STAT_W-1:0] status_c;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;

    assign pos_x   = CMP_W'(position);
    assign cnt_x   = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign cnt_inc = count_reg + CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        op_c       = '0;
        idx        = '0;
        rd_c       = 1'b0;
        found_c    = 1'b0;
        status_c   = ST_DONE;
        count_next = count_reg;
        case (cmd)
            CMD_APPEND:
            begin
                if (full)
                    status_c = ST_FULL;
                else
                begin
                    op_c.ins   = 1'b1;
                    idx        = count_reg[IDX_W-1:0];
                    count_next = cnt_inc;
                end
            end
            CMD_INSERT:
            begin
                if (pos_x > cnt_x)
                    status_c = ST_RANGE;
                else if (full)
                    status_c = ST_FULL;
                else
                begin
                    op_c.ins   = 1'b1;
                    idx        = pos_x[IDX_W-1:0];
                    count_next = cnt_inc;
                end
            end
            CMD_READ:
            begin
                if (pos_x >= cnt_x)
                    status_c = ST_RANGE;
                else
                begin
                    rd_c = 1'b1;
                    idx  = pos_x[IDX_W-1:0];
                end
            end
            CMD_READ_END:
            begin
                if (empty)
                    status_c = ST_RANGE;
                else
                begin
                    rd_c = 1'b1;
                    idx  = cnt_dec[IDX_W-1:0];
                end
            end
            CMD_CONTAINS:
            begin
                found_c = any_hit;
            end
            CMD_REMOVE:
            begin
                if (pos_x >= cnt_x)
                    status_c = ST_RANGE;
                else
                begin
                    rd_c       = 1'b1;
                    op_c.rem   = 1'b1;
                    idx        = pos_x[IDX_W-1:0];
                    count_next = cnt_dec;
                end
            end
            CMD_POP:
            begin
                if (empty)
                    status_c = ST_RANGE;
                else
                begin
                    rd_c       = 1'b1;
                    idx        = cnt_dec[IDX_W-1:0];
                    count_next = cnt_dec;
                end
            end
            default:
            begin
                status_c = ST_DONE;
            end
        endcase
    end

    assign op = fire ? op_c : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_c;
            data_reg   <= rd_c ? sel_word : '0;
            found_reg  <= found_c;
            length_reg <= POS_W'(count_next);
        end
    end

    assign count     = count_reg;
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign found     = found_reg;
    assign length    = length_reg;

endmodule

// ===== sv/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_engine
// Fixed-capacity ordered list of words built as a shifting row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group. Each request carries a command
//   (append, insert, read at, read last, contains, remove at, remove last),
//   a value and a position. Every request yields exactly one response on the
//   m_axis group: status, data word, found flag and the list length after
//   the command.
// Response: the response is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken. All cells
//   update on the same clock edge (insert shifts up, remove shifts down,
//   every cell compares for contains).
// Stall: the response sits in an output register. While m_axis_tready is
//   low the response holds and s_axis_tready drops; a new request is taken
//   in the same cycle the waiting response is taken.
// Reset: rst_n (async, active low) empties the list and drops m_axis_tvalid.
//   Entry storage is not cleared; slots past the length are never observed.
// ----------------------------------------------------------------------------
module array_list_engine
    import ale_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] cmd, [34:3] value_in, [41:35] position, [47:42] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [33:2] data_out, [34] found, [41:35] length, [47:42] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // request fields
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] value_in;
    logic [POS_W-1:0]  position;

    assign cmd      = s_axis_tdata[CMD_W-1:0];
    assign value_in = s_axis_tdata[CMD_W+WORD_W-1:CMD_W];
    assign position = s_axis_tdata[IN_FIELDS_W-1:CMD_W+WORD_W];

    // value at cell width, and selected entry back at word width
    logic [VALUE_WIDTH-1:0] value_w;
    logic [VALUE_WIDTH-1:0] sel_wide;
    logic [WORD_W-1:0]      sel_word;

    generate
        if (VALUE_WIDTH > WORD_W)
        begin : g_wide
            assign value_w  = {{(VALUE_WIDTH-WORD_W){1'b0}}, value_in};
            assign sel_word = sel_wide[WORD_W-1:0];
        end
        else if (VALUE_WIDTH == WORD_W)
        begin : g_same
            assign value_w  = value_in;
            assign sel_word = sel_wide;
        end
        else
        begin : g_narrow
            assign value_w  = value_in[VALUE_WIDTH-1:0];
            assign sel_word = {{(WORD_W-VALUE_WIDTH){1'b0}}, sel_wide};
        end
    endgenerate

    // control
    cell_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
    logic              any_hit;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] data_out;
    logic              found;
    logic [POS_W-1:0]  length;

    ale_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .cmd       (cmd),
        .position  (position),
        .sel_word  (sel_word),
        .any_hit   (any_hit),
        .op        (op),
        .idx       (idx),
        .count     (count),
        .rsp_valid (m_axis_tvalid),
        .rsp_ready (m_axis_tready),
        .status    (status),
        .data_out  (data_out),
        .found     (found),
        .length    (length)
    );

    // cell row: each cell sees its left and right neighbor
    logic [VALUE_WIDTH-1:0] cell_entry [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_rdata [DEPTH];
    logic [DEPTH-1:0]       cell_hit;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_w;
            logic [VALUE_WIDTH-1:0] right_w;

            if (i == 0)
            begin : g_first
                assign left_w = value_w;
            end
            else
            begin : g_mid_l
                assign left_w = cell_entry[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_w = cell_entry[i];
            end
            else
            begin : g_mid_r
                assign right_w = cell_entry[i+1];
            end

            ale_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .IDX_W       (IDX_W),
                .CNT_W       (CNT_W),
                .INDEX       (i)
            ) u_cell (
                .clk   (clk),
                .op    (op),
                .idx   (idx),
                .count (count),
                .value (value_w),
                .left  (left_w),
                .right (right_w),
                .entry (cell_entry[i]),
                .hit   (cell_hit[i]),
                .rdata (cell_rdata[i])
            );
        end
    endgenerate

    // only the addressed cell drives nonzero read data
    always_comb
    begin
        sel_wide = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_wide = sel_wide | cell_rdata[i];
        end
    end

    assign any_hit = |cell_hit;

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, length, found, data_out, status};

endmodule

// ===== sv/ale_checker.sv =====
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks on the list engine response stream, bound to the top.
// ----------------------------------------------------------------------------
module ale_checker
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [STAT_W-1:0] rsp_status;
    logic [WORD_W-1:0] rsp_data;
    logic              rsp_found;
    logic [POS_W-1:0]  rsp_length;

    assign rsp_status = m_axis_tdata[STAT_W-1:0];
    assign rsp_data   = m_axis_tdata[O_FOUND_BIT-1:O_DATA_LSB];
    assign rsp_found  = m_axis_tdata[O_FOUND_BIT];
    assign rsp_length = m_axis_tdata[OUT_FIELDS_W-1:O_LEN_LSB];

    // a stalled response stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("response dropped while stalled");

    // an accepted request always produces a response next cycle
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request gave no response");

    // only the three defined status codes appear
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (rsp_status == ST_DONE || rsp_status == ST_FULL ||
                           rsp_status == ST_RANGE))
        else $error("undefined status code");

    // a match is only reported by a successful lookup, with no data
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && rsp_found |-> rsp_status == ST_DONE && rsp_data == '0)
        else $error("found flag with status or data");

    // a full rejection leaves the list at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && rsp_status == ST_FULL |-> rsp_length == POS_W'(DEPTH))
        else $error("full status with list below capacity");

endmodule

bind array_list_engine ale_checker #(
    .DEPTH (DEPTH)
) u_ale_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
